// ===== design/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants shared by the round-robin task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package rrts_pkg;
  localparam int unsigned MaxTasks = 32;
  localparam int unsigned IdW = $clog2(MaxTasks);
  localparam int unsigned CntW = IdW + 1;
  localparam int unsigned TimeW = 32;
  localparam logic [7:0] ResetSlice = 8'd6;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_DONE   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_HEAD,
    ST_INS_WALK,
    ST_INS_CMP,
    ST_INS_LINK,
    ST_TICK_RD,
    ST_TICK_CMP,
    ST_TICK_SCHED,
    ST_DISP,
    ST_DONE_CHK,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [TimeW-1:0] arrival_time;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0] running_task;
    logic           running_valid;
    logic           switched;
    logic [IdW-1:0] created_id;
    logic           all_finished;
    logic           status;
  } rsp_t;
endpackage
`default_nettype wire

// ===== design/rrts_req_if.sv =====
// ----------------------------------------------------------------------------
// rrts_req_if
// Valid/ready channel carrying one scheduler request.
// ----------------------------------------------------------------------------
`default_nettype none
interface rrts_req_if import rrts_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/rrts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rrts_rsp_if
// Valid/ready channel carrying one scheduler response.
// ----------------------------------------------------------------------------
`default_nettype none
interface rrts_rsp_if import rrts_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/rrts_ram.sv =====
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rrts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== design/round_robin_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin scheduler with a time-sorted arrival list and a ready FIFO.
// ----------------------------------------------------------------------------
// One request is handled at a time under a small sequencer; ready is low until
// the response has been taken. A create walks the sorted arrival list through
// the time and link RAMs one entry at a time, and a tick moves arrived tasks
// to the ready FIFO one at a time. This is bound by the single read port of
// each RAM and the one shared 32-bit compare.
`default_nettype none
module round_robin_task_scheduler
  import rrts_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  rrts_req_if.sink        req,
  rrts_rsp_if.source      rsp
);
  state_e state_q, state_d;

  logic [7:0]       slice_cfg_q;
  logic [1:0]       cmd_q;
  logic [TimeW-1:0] t_q;
  logic [IdW-1:0]   arr_head_q;
  logic [CntW-1:0]  arr_cnt_q;
  logic [IdW-1:0]   rdy_head_q;
  logic [CntW-1:0]  rdy_cnt_q;
  logic [IdW-1:0]   cur_q;
  logic             cur_valid_q;
  logic [TimeW-1:0] now_q;
  logic [7:0]       slice_left_q;
  logic [CntW-1:0]  next_id_q;
  logic [IdW-1:0]   p_q;
  logic [CntW-1:0]  steps_q;
  logic [IdW-1:0]   prev_q;
  logic             prev_valid_q;
  rsp_t             rsp_q;

  // RAM ports
  logic             tm_we, lk_we, rf_we;
  logic [IdW-1:0]   tm_wa, tm_ra, lk_wa, lk_ra, rf_wa, rf_ra;
  logic [TimeW-1:0] tm_wd, tm_rd;
  logic [IdW-1:0]   lk_wd, lk_rd, rf_wd, rf_rd;
  logic             lk2_we;
  logic [IdW-1:0]   lk2_wa, lk2_wd;

  rrts_ram #(.Width(TimeW), .Depth(MaxTasks)) u_times (
    .clk_i, .we_i(tm_we), .waddr_i(tm_wa), .wdata_i(tm_wd), .raddr_i(tm_ra),
    .rdata_o(tm_rd));
  rrts_ram #(.Width(IdW), .Depth(MaxTasks)) u_links (
    .clk_i, .we_i(lk2_we), .waddr_i(lk2_wa), .wdata_i(lk2_wd), .raddr_i(lk_ra),
    .rdata_o(lk_rd));
  rrts_ram #(.Width(IdW), .Depth(MaxTasks)) u_ready (
    .clk_i, .we_i(rf_we), .waddr_i(rf_wa), .wdata_i(rf_wd), .raddr_i(rf_ra),
    .rdata_o(rf_rd));

  logic             accept;
  logic [IdW-1:0]   new_id;
  logic             le;
  logic [TimeW-1:0] cmp_a, cmp_b;
  logic             ins_more;
  logic [IdW-1:0]   rdy_tail;

  assign accept   = req.valid && req.ready;
  assign new_id   = next_id_q[IdW-1:0];
  assign rdy_tail = rdy_head_q + rdy_cnt_q[IdW-1:0];
  // shared compare: t <= head time, then list time <= t (create), time <= now (tick)
  assign cmp_a = (cmd_q == CMD_CREATE && steps_q == '0) ? t_q : tm_rd;
  assign cmp_b = (cmd_q == CMD_CREATE) ? ((steps_q == '0) ? tm_rd : t_q) : now_q;
  assign le    = cmp_a <= cmp_b;
  assign ins_more = (steps_q != '0) && (steps_q < arr_cnt_q) && le;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(req.payload.cmd))
            CMD_CREATE: state_d = (next_id_q >= CntW'(MaxTasks)) ? ST_OUT :
                                  (arr_cnt_q == '0) ? ST_INS_LINK : ST_INS_HEAD;
            CMD_TICK:   state_d = ST_TICK_RD;
            CMD_DONE:   state_d = ST_DONE_CHK;
            default:    state_d = ST_OUT;
          endcase
        end
      end
      ST_INS_HEAD: state_d = ST_INS_CMP;
      ST_INS_WALK: state_d = ST_INS_CMP;
      ST_INS_CMP: begin
        if (steps_q == '0) begin
          state_d = le ? ST_INS_LINK : ST_INS_WALK;
        end else if (ins_more) begin
          state_d = ST_INS_WALK;
        end else begin
          state_d = ST_INS_LINK;
        end
      end
      ST_INS_LINK: state_d = ST_OUT;
      ST_TICK_RD: state_d = (arr_cnt_q == '0) ? ST_TICK_SCHED : ST_TICK_CMP;
      ST_TICK_CMP: state_d = le ? ST_TICK_RD : ST_TICK_SCHED;
      ST_TICK_SCHED: state_d = ST_DISP;
      ST_DISP: state_d = ST_OUT;
      ST_DONE_CHK: state_d = ST_DISP;
      ST_OUT: if (rsp.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    tm_we = 1'b0; tm_wa = new_id; tm_wd = t_q; tm_ra = arr_head_q;
    lk_we = 1'b0; lk_wa = new_id; lk_wd = arr_head_q; lk_ra = p_q;
    rf_we = 1'b0; rf_wa = rdy_tail; rf_wd = arr_head_q; rf_ra = rdy_head_q;
    case (state_q)
      ST_INS_HEAD: tm_ra = arr_head_q;
      ST_INS_WALK: tm_ra = lk_rd;
      ST_INS_CMP: lk_ra = ins_more ? lk_rd : p_q;
      ST_INS_LINK: begin
        tm_we = 1'b1;
        lk_we = 1'b1;
        if (arr_cnt_q == '0 || steps_q == '0) begin
          lk_wd = arr_head_q;
        end else begin
          lk_wd = lk_rd;
        end
      end
      ST_TICK_RD: lk_ra = arr_head_q;
      ST_TICK_CMP: begin
        lk_ra = arr_head_q;
        rf_we = le && (rdy_cnt_q < CntW'(MaxTasks));
      end
      ST_TICK_SCHED: begin
        rf_we = cur_valid_q && slice_left_q <= 8'd1 && (rdy_cnt_q != '0);
        rf_wd = cur_q;
      end
      default: ;
    endcase
  end

  logic link_fix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slice_cfg_q  <= ResetSlice;
      arr_head_q   <= '0;
      arr_cnt_q    <= '0;
      rdy_head_q   <= '0;
      rdy_cnt_q    <= '0;
      cur_q        <= '0;
      cur_valid_q  <= 1'b0;
      now_q        <= '0;
      slice_left_q <= ResetSlice;
      next_id_q    <= '0;
      link_fix_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) slice_cfg_q <= cfg_wdata_i;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q        <= req.payload.cmd;
            t_q          <= req.payload.arrival_time;
            p_q          <= arr_head_q;
            steps_q      <= '0;
            prev_q       <= cur_q;
            prev_valid_q <= cur_valid_q;
            rsp_q        <= '0;
            if (req.payload.cmd == CMD_CREATE && next_id_q >= CntW'(MaxTasks)) begin
              rsp_q.status <= 1'b1;
            end
            if (req.payload.cmd == CMD_TICK) now_q <= now_q + 1'b1;
          end
        end
        ST_INS_CMP: begin
          if (steps_q == '0) begin
            if (!le) steps_q <= CntW'(1);
          end else if (ins_more) begin
            p_q     <= lk_rd;
            steps_q <= steps_q + 1'b1;
          end
        end
        ST_INS_LINK: begin
          if (arr_cnt_q == '0 || steps_q == '0) begin
            arr_head_q <= new_id;
          end else begin
            link_fix_q <= 1'b1;
          end
          arr_cnt_q     <= arr_cnt_q + 1'b1;
          next_id_q     <= next_id_q + 1'b1;
          rsp_q.created_id <= new_id;
        end
        ST_TICK_CMP: begin
          if (le) begin
            arr_head_q <= lk_rd;
            arr_cnt_q  <= arr_cnt_q - 1'b1;
            if (rdy_cnt_q < CntW'(MaxTasks)) rdy_cnt_q <= rdy_cnt_q + 1'b1;
          end
        end
        ST_TICK_SCHED: begin
          if (cur_valid_q) begin
            if (slice_left_q <= 8'd1) begin
              // empty FIFO: the expired task is dispatched again right away
              if (rdy_cnt_q != '0) begin
                rdy_cnt_q   <= rdy_cnt_q + 1'b1;
                cur_valid_q <= 1'b0;
              end else begin
                slice_left_q <= slice_cfg_q;
              end
            end else begin
              slice_left_q <= slice_left_q - 1'b1;
            end
          end
        end
        ST_DONE_CHK: begin
          cur_valid_q <= 1'b0;
          cur_q       <= '0;
        end
        ST_DISP: begin
          if (!cur_valid_q && rdy_cnt_q != '0 &&
              (cmd_q == CMD_TICK || prev_valid_q)) begin
            cur_q        <= rf_rd;
            cur_valid_q  <= 1'b1;
            slice_left_q <= slice_cfg_q;
            rdy_head_q   <= rdy_head_q + 1'b1;
            rdy_cnt_q    <= rdy_cnt_q - 1'b1;
          end
        end
        default: ;
      endcase
      if (state_q == ST_OUT && link_fix_q) link_fix_q <= 1'b0;
    end
  end

  // deferred link p -> id for an insert after the head, written during ST_OUT
  logic           fix_we;
  logic [IdW-1:0] fix_pa, fix_id;
  assign fix_we = link_fix_q && state_q == ST_OUT;
  assign fix_pa = p_q;
  assign fix_id = next_id_q[IdW-1:0] - 1'b1;

  assign lk2_we = lk_we || fix_we;
  assign lk2_wa = fix_we ? fix_pa : lk_wa;
  assign lk2_wd = fix_we ? fix_id : lk_wd;

  // response fields computed from final state
  logic [IdW-1:0] out_task;
  logic           sw;
  logic           fin;
  assign out_task = cur_valid_q ? cur_q : '0;
  assign sw = (cmd_q == CMD_TICK) ? ((cur_valid_q != prev_valid_q) ||
              (cur_valid_q && cur_q != prev_q)) :
              (cmd_q == CMD_DONE) ? prev_valid_q : 1'b0;
  assign fin = (cmd_q == CMD_DONE) && rdy_cnt_q == '0 && arr_cnt_q == '0;

  assign req.ready = (state_q == ST_IDLE);
  assign rsp.valid = (state_q == ST_OUT);
  always_comb begin
    rsp.payload               = rsp_q;
    rsp.payload.running_task  = out_task;
    rsp.payload.running_valid = cur_valid_q;
    rsp.payload.switched      = sw;
    rsp.payload.all_finished  = fin;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arr_cnt_q <= CntW'(MaxTasks) && rdy_cnt_q <= CntW'(MaxTasks))
    else $error("queue count overflow");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready) else $error("request taken while busy");
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req.ready) else $error("ready held after a request");
  a_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q <= CntW'(MaxTasks)) else $error("task id overflow");
`endif
endmodule
`default_nettype wire
